// ===== hw/rtl/ffc_pkg.sv =====
// Shared types and constants of the flat-field correction block.
package ffc_pkg;

	// Field and register widths
	localparam int DIM_CFG_W   = 12;
	localparam int BORDER_W    = 10;
	localparam int PIX_W       = 16;
	localparam int MEAN_W      = 24;
	localparam int FRAC_W      = 8;
	localparam int SUM_W       = 38;
	localparam int MUL1_W      = PIX_W + MEAN_W;
	localparam int MAX_DIM_DEF = 2048;

	// Register reset values
	localparam logic [DIM_CFG_W-1:0] WIDTH_RST  = 12'd1628;
	localparam logic [DIM_CFG_W-1:0] HEIGHT_RST = 12'd1628;
	localparam logic [BORDER_W-1:0]  BORDER_RST = 10'd100;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BORDER_SIZE  = 2'd2;

	// Input word modes
	localparam logic MODE_GAIN    = 1'b0;
	localparam logic MODE_CORRECT = 1'b1;

	// Saturation values
	localparam logic [PIX_W-1:0]  PIX_MAX  = '1;
	localparam logic [MEAN_W-1:0] MEAN_MAX = '1;

	typedef struct packed {
		logic [BORDER_W-1:0]  border_size;
		logic [DIM_CFG_W-1:0] frame_height;
		logic [DIM_CFG_W-1:0] frame_width;
	} cfg_t;

endpackage

// ===== hw/rtl/flat_field_correction.sv =====
// Flat-field correction top level: config port, sequencer, shared divider.
//
// Input words arrive on s_axis with tuser selecting the mode. A gain word
// (mode 0) steps the raster position and adds its gain into the window sum;
// it is taken without leaving the idle state and gives no output, except
// the last word of a frame, which starts a division of sum*256 by the
// window size and emits the new 16.8 mean. A correction word (mode 1)
// gives one output word: |raw-dark| * mean divided by gain*256, clamped
// to 16 bits. A zero gain or an empty window skips the division.
// The item rate is set by the single radix-2 divider, one quotient bit per
// cycle: 40 quotient bits for a correction, 46 for a frame mean, plus the
// load, multiply, check and hand-off states. s_axis_tready is high only
// while no word is in work. The result sits in an output register, so the
// next word is taken while it waits for m_axis_tready; a new result waits
// in the sequencer until that register is free. Reset clears position,
// window sum, stored mean and output valid, and loads the register
// defaults 1628 x 1628 with a border of 100. The user is to write
// registers over the APB port only while the block is idle; the block
// itself does not enforce it.
module flat_field_correction import ffc_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input words
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // raw_pixel, dark_pixel, gain_pixel
	input  logic [0:0]  s_axis_tuser,  // mode
	// output words
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // corrected_pixel, gain_mean_fx
	output logic [1:0]  m_axis_tuser   // zero_gain, saturated
);

	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int POS_W  = $clog2(MAX_DIM);
	localparam int A_W    = (PIX_W > DIM_W) ? PIX_W : DIM_W;
	localparam int B_W    = (MEAN_W > DIM_W) ? MEAN_W : DIM_W;
	localparam int DIV_W  = (MEAN_W > 2 * DIM_W) ? MEAN_W : 2 * DIM_W;
	localparam int NUM_W  = SUM_W + FRAC_W;
	localparam int IT_W   = $clog2(NUM_W + 1);
	localparam int SHIFT1 = NUM_W - MUL1_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CHECK,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t              state_q;
	cfg_t                cfg_q;
	logic [MEAN_W-1:0]   gain_mean_q;
	logic                mode_q;
	logic [PIX_W-1:0]    gain_q;
	logic [A_W-1:0]      op_a_q;
	logic [B_W-1:0]      op_b_q;
	logic [NUM_W-1:0]    num_q;
	logic [DIV_W-1:0]    den_q;
	logic [IT_W-1:0]     iters_q;
	logic                special_q;
	logic [A_W+B_W-1:0]  prod;
	logic                s_fire;
	logic                cfg_wr;
	logic                s_mode;
	logic [PIX_W-1:0]    s_raw;
	logic [PIX_W-1:0]    s_dark;
	logic [PIX_W-1:0]    s_gain;
	logic [PIX_W-1:0]    abs_diff;
	logic                frame_end;
	logic [SUM_W-1:0]    sum_total;
	logic [DIM_W-1:0]    span_w;
	logic [DIM_W-1:0]    span_h;
	logic                div_start;
	logic                div_done;
	logic [NUM_W-1:0]    quot;
	logic                out_free;
	logic                out_load;
	logic [PIX_W-1:0]    res_corr;
	logic [MEAN_W-1:0]   res_mean;
	logic                res_zg;
	logic                res_sat;

	// Unpack the input word
	assign s_mode   = s_axis_tuser[0];
	assign s_raw    = s_axis_tdata[15:0];
	assign s_dark   = s_axis_tdata[31:16];
	assign s_gain   = s_axis_tdata[47:32];
	assign abs_diff = (s_raw >= s_dark) ? s_raw - s_dark : s_dark - s_raw;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign out_load      = (state_q == ST_OUT) && out_free;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= WIDTH_RST;
			cfg_q.frame_height <= HEIGHT_RST;
			cfg_q.border_size  <= BORDER_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= pwdata[DIM_CFG_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[DIM_CFG_W-1:0];
				REG_BORDER_SIZE:  cfg_q.border_size  <= pwdata[BORDER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_FRAME_WIDTH:  prdata = 32'(cfg_q.frame_width);
			REG_FRAME_HEIGHT: prdata = 32'(cfg_q.frame_height);
			REG_BORDER_SIZE:  prdata = 32'(cfg_q.border_size);
			default:          prdata = '0;
		endcase
	end

	// Raster tracking and window sum
	ffc_frame #(
		.MAX_DIM (MAX_DIM),
		.DIM_W   (DIM_W),
		.POS_W   (POS_W)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.step      (s_fire && (s_mode == MODE_GAIN)),
		.gain      (s_gain),
		.frame_end (frame_end),
		.sum_total (sum_total),
		.span_w    (span_w),
		.span_h    (span_h)
	);

	// Shared multiplier: window size in mode 0, |raw-dark| * mean in mode 1
	assign prod = op_a_q * op_b_q;

	// Shared divider
	assign div_start = (state_q == ST_CHECK) && !special_q;

	ffc_div #(
		.NUM_W (NUM_W),
		.DEN_W (DIV_W),
		.IT_W  (IT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (num_q),
		.denom  (den_q),
		.iters  (iters_q),
		.done   (div_done),
		.quot   (quot)
	);

	// Load operands at accept, then products and special cases
	always_ff @(posedge clk) begin
		if (s_fire) begin
			mode_q <= s_mode;
			gain_q <= s_gain;
			if (s_mode == MODE_GAIN) begin
				op_a_q <= A_W'(span_w);
				op_b_q <= B_W'(span_h);
				num_q  <= {sum_total, {FRAC_W{1'b0}}};
			end else begin
				op_a_q <= A_W'(abs_diff);
				op_b_q <= B_W'(gain_mean_q);
			end
		end
		if (state_q == ST_MUL) begin
			if (mode_q == MODE_GAIN) begin
				den_q     <= DIV_W'(prod);
				iters_q   <= IT_W'(NUM_W);
				special_q <= (prod == '0);
			end else begin
				num_q     <= {prod[MUL1_W-1:0], {SHIFT1{1'b0}}};
				den_q     <= DIV_W'({gain_q, {FRAC_W{1'b0}}});
				iters_q   <= IT_W'(MUL1_W);
				special_q <= (gain_q == '0);
			end
		end
	end

	// Clamp the quotient into the result fields
	always_comb begin
		if (mode_q == MODE_GAIN) begin
			res_corr = '0;
			res_sat  = 1'b0;
			res_zg   = special_q;
			if (special_q)
				res_mean = '0;
			else if (quot[NUM_W-1:MEAN_W] != '0)
				res_mean = MEAN_MAX;
			else
				res_mean = quot[MEAN_W-1:0];
		end else begin
			res_mean = gain_mean_q;
			res_zg   = special_q;
			if (special_q) begin
				res_corr = PIX_MAX;
				res_sat  = 1'b0;
			end else if (quot[NUM_W-1:PIX_W] != '0) begin
				res_corr = PIX_MAX;
				res_sat  = 1'b1;
			end else begin
				res_corr = quot[PIX_W-1:0];
				res_sat  = 1'b0;
			end
		end
	end

	// Sequencer, stored mean and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			gain_mean_q   <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= '0;
		end else begin
			// Load a new word or drop valid once the receiver takes it
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
				m_axis_tdata  <= {res_mean, res_corr};
				m_axis_tuser  <= {res_sat, res_zg};
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire && (s_mode == MODE_CORRECT || frame_end))
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= special_q ? ST_OUT : ST_DIV;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						if (mode_q == MODE_GAIN)
							gain_mean_q <= res_mean;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A new output word only comes from the hand-off state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
		else $error("output word raised outside hand-off");

	// The divider finishes only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider done outside divide state");

	// The stored mean changes only when a frame mean is handed off
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(gain_mean_q) |-> $past(state_q == ST_OUT && mode_q == MODE_GAIN))
		else $error("gain mean changed outside frame end");

endmodule

// ===== hw/rtl/ffc_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module ffc_div import ffc_pkg::*; #(
	parameter int NUM_W = 46,
	parameter int DEN_W = 24,
	parameter int IT_W  = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	input  logic [IT_W-1:0]  iters,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [IT_W-1:0]  cnt_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W+1:0] trial;
	logic             fits;

	// Shift in the next numerator bit and try one subtraction
	always_comb begin
		rem_sh = {rem_q, quo_q[NUM_W-1]};
		trial  = {1'b0, rem_sh} - {2'b00, den_q};
		fits   = ~trial[DEN_W+1];
	end

	// Count iterations and flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= iters;
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == IT_W'(1));
			end
		end
	end

	// Hold operands, remainder and the quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// ===== hw/rtl/ffc_frame.sv =====
// Raster position tracker and window sum for gain-map frames.
module ffc_frame import ffc_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF,
	parameter int DIM_W   = $clog2(MAX_DIM + 1),
	parameter int POS_W   = $clog2(MAX_DIM)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             step,
	input  logic [PIX_W-1:0] gain,
	output logic             frame_end,
	output logic [SUM_W-1:0] sum_total,
	output logic [DIM_W-1:0] span_w,
	output logic [DIM_W-1:0] span_h
);

	localparam int EW = ((DIM_W > BORDER_W + 1) ? DIM_W : BORDER_W + 1) + 1;

	logic [POS_W-1:0] col_q;
	logic [POS_W-1:0] row_q;
	logic [SUM_W-1:0] sum_q;
	logic [EW-1:0]    w_e;
	logic [EW-1:0]    h_e;
	logic [EW-1:0]    b_e;
	logic [EW-1:0]    two_b;
	logic [EW-1:0]    col_e;
	logic [EW-1:0]    row_e;
	logic             in_window;
	logic             row_end;
	logic             last_row;

	// Clamp dimensions to 1..MAX_DIM
	always_comb begin
		if (cfg.frame_width == '0)
			w_e = EW'(1);
		else if (EW'(cfg.frame_width) > EW'(MAX_DIM))
			w_e = EW'(MAX_DIM);
		else
			w_e = EW'(cfg.frame_width);
		if (cfg.frame_height == '0)
			h_e = EW'(1);
		else if (EW'(cfg.frame_height) > EW'(MAX_DIM))
			h_e = EW'(MAX_DIM);
		else
			h_e = EW'(cfg.frame_height);
	end

	// Window test, row and frame end, next sum
	always_comb begin
		b_e       = EW'(cfg.border_size);
		two_b     = EW'({cfg.border_size, 1'b0});
		col_e     = EW'(col_q);
		row_e     = EW'(row_q);
		in_window = (col_e >= b_e) && ((col_e + b_e) < w_e) &&
		            (row_e >= b_e) && ((row_e + b_e) < h_e);
		row_end   = col_e >= (w_e - 1'b1);
		last_row  = row_e >= (h_e - 1'b1);
		frame_end = step && row_end && last_row;
		sum_total = sum_q + (in_window ? SUM_W'(gain) : '0);
		span_w    = (two_b >= w_e) ? '0 : DIM_W'(w_e - two_b);
		span_h    = (two_b >= h_e) ? '0 : DIM_W'(h_e - two_b);
	end

	// Advance position and accumulate on each gain word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			sum_q <= '0;
		end else if (step) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= last_row ? '0 : POS_W'(row_e + 1'b1);
			end else begin
				col_q <= POS_W'(col_e + 1'b1);
			end
			sum_q <= frame_end ? '0 : sum_total;
		end
	end

endmodule
